@@ src/nfud_pkg.sv @@
// Package for the nearest free unit dispatcher: opcodes, status codes, state type.
// No dependencies.
`default_nettype none
package nfud_pkg;
  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_MOVE = 2'd1,
    OP_SET  = 2'd2,
    OP_REQ  = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_ASSIGNED = 3'd0,
    ST_QUEUED   = 3'd1,
    ST_QFULL    = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_DONE     = 3'd4,
    ST_TFULL    = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIND,
    S_FIND_END,
    S_SCAN,
    S_SCAN_END,
    S_QREAD,
    S_QWAIT,
    S_APPLY,
    S_EMIT
  } state_e;

  localparam int unsigned MaxResults = 64;
endpackage
`default_nettype wire

@@ src/nfud_dist.sv @@
// Squared distance between two packed 16-bit points; the squares are registered and their sum is combinational.
// Depends on nothing.
`default_nettype none
module nfud_dist (
  input  wire logic        clk_i,
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  output logic      [32:0] dist_o
);
  logic signed [16:0] dx_d, dy_d;
  logic [33:0] sqx_q, sqy_q;
  logic signed [33:0] px, py;

  assign dx_d = 17'(signed'(a_i[15:0]))  - 17'(signed'(b_i[15:0]));
  assign dy_d = 17'(signed'(a_i[31:16])) - 17'(signed'(b_i[31:16]));
  assign px = dx_d * dx_d;
  assign py = dy_d * dy_d;

  always_ff @(posedge clk_i) begin
    sqx_q <= unsigned'(px);
    sqy_q <= unsigned'(py);
  end
  assign dist_o = 33'(sqx_q + sqy_q);
endmodule
`default_nettype wire

@@ src/nearest_free_unit_dispatcher_top.sv @@
// Top level of the nearest free unit dispatcher.
// Depends on nfud_pkg and nfud_dist.
//
// Usage:
// - Input channel (valid_i/stall_o) carries one command transaction: add a
//   unit, move a unit, set a unit free or busy, or a service request.
// - Output channel (valid_o/stall_i) carries result transactions; last_o marks
//   the final result of one command. A set-free command may yield up to 63
//   assignments (queued requests served in order) followed by done.
// - The unit table sits in a synchronous memory read one entry per cycle.
//   A request scans all filled entries; lookups by id scan the same way.
//   Each queued request served costs one scan.
// - Queue entries live in a second synchronous memory (registered read).
// - One command is worked at a time; stall_o is high while a command is in
//   progress or a result waits in the output register.
// - When the receiver stalls, the result holds in the output register and
//   the sequencer waits; nothing is lost.
// - Reset clears the unit count, the free flags (flip-flops) and the queue
//   pointers; memory contents are undefined until written, and data read from
//   an entry that was never written is never used.
`default_nettype none
module nearest_free_unit_dispatcher_top #(
  parameter int unsigned MAX_UNITS   = 32,
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  output logic             stall_o,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [15:0] unit_id_i,
  input  wire logic [15:0] client_id_i,
  input  wire logic signed [15:0] pos_x_i,
  input  wire logic signed [15:0] pos_y_i,
  input  wire logic signed [15:0] dest_x_i,
  input  wire logic signed [15:0] dest_y_i,
  input  wire logic        free_flag_i,
  output logic             valid_o,
  input  wire logic        stall_i,
  output logic [2:0]       status_o,
  output logic [15:0]      unit_id_res_o,
  output logic [15:0]      client_id_res_o,
  output logic [32:0]      dist_sq_o,
  output logic             last_o
);
  localparam int unsigned UW = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
  localparam int unsigned CW = $clog2(MAX_UNITS + 1);
  localparam int unsigned QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned FW = $clog2(QUEUE_DEPTH + 1);

  // Memories
  logic [47:0] umem [MAX_UNITS];     // {pos, id}
  logic [79:0] qmem [QUEUE_DEPTH];   // {dest, pickup, client}
  logic [47:0] urd_q;
  logic [79:0] qrd_q;
  logic        uwe;
  logic [UW-1:0] uwa, ura;
  logic [47:0] uwd;
  logic        qwe;
  logic [79:0] qwd;
  logic [QW-1:0] qra;

  logic [MAX_UNITS-1:0] free_q, free_d;
  logic [CW-1:0] count_q, count_d;
  logic [QW-1:0] head_q, head_d, tail_q, tail_d;
  logic [FW-1:0] fill_q, fill_d;

  nfud_pkg::state_e st_q, st_d;
  // command latch
  logic [1:0]  op_q;
  logic [15:0] uid_q, cid_q, cid_d;
  logic [31:0] pos_q, pick_d, dest_d;
  logic [31:0] pick_q, dest_q;
  logic        flag_q;
  // scan
  logic [CW-1:0] idx_q, idx_d;       // address issued
  logic [CW-1:0] p1_q, p2_q;         // entry index at pipe stages
  logic          v1_q, v2_q, f1_q, f2_q;
  logic [15:0]   id2_q;
  logic          hit_q, hit_d;
  logic [UW-1:0] best_q, best_d;
  logic [32:0]   bd_q, bd_d;
  logic [15:0]   bid_q, bid_d;
  logic [6:0]    nres_q, nres_d;
  logic          serve_q, serve_d;
  // output register
  logic          ov_q, ov_d;
  logic [2:0]    ost_q, ost_d;
  logic [15:0]   ouid_q, ouid_d, ocid_q, ocid_d;
  logic [32:0]   odist_q, odist_d;
  logic          olast_q, olast_d;
  logic [32:0]   cand_dist;

  assign valid_o = ov_q;
  assign status_o = ost_q;
  assign unit_id_res_o = ouid_q;
  assign client_id_res_o = ocid_q;
  assign dist_sq_o = odist_q;
  assign last_o = olast_q;
  assign stall_o = (st_q != nfud_pkg::S_IDLE) || ov_q;
  logic acc_in, out_free;
  assign acc_in = valid_i && !stall_o;
  assign out_free = !ov_q || !stall_i;

  always_ff @(posedge clk_i) begin
    if (uwe) umem[uwa] <= uwd;
    urd_q <= umem[ura];
    if (qwe) qmem[tail_q] <= qwd;
    qrd_q <= qmem[qra];
  end

  nfud_dist u_dist (.clk_i, .a_i(urd_q[47:16]), .b_i(pick_q), .dist_o(cand_dist));

  assign ura = idx_q[UW-1:0];
  assign qra = head_q;

  always_comb begin
    st_d = st_q;
    free_d = free_q; count_d = count_q; head_d = head_q; tail_d = tail_q;
    fill_d = fill_q; idx_d = idx_q; hit_d = hit_q; best_d = best_q;
    bd_d = bd_q; bid_d = bid_q; nres_d = nres_q; serve_d = serve_q;
    cid_d = cid_q; pick_d = pick_q; dest_d = dest_q;
    ov_d = ov_q && stall_i; ost_d = ost_q; ouid_d = ouid_q; ocid_d = ocid_q;
    odist_d = odist_q; olast_d = olast_q;
    uwe = 1'b0; uwa = '0; uwd = '0; qwe = 1'b0; qwd = '0;
    case (st_q)
      nfud_pkg::S_IDLE: begin
        if (acc_in) begin
          idx_d = '0; hit_d = 1'b0; nres_d = '0; serve_d = 1'b0;
          cid_d = client_id_i;
          pick_d = {pos_y_i, pos_x_i};
          dest_d = {dest_y_i, dest_x_i};
          if (opcode_i == nfud_pkg::OP_ADD) st_d = nfud_pkg::S_APPLY;
          else if (opcode_i == nfud_pkg::OP_REQ) st_d = nfud_pkg::S_SCAN;
          else st_d = nfud_pkg::S_FIND;
        end
      end
      nfud_pkg::S_FIND, nfud_pkg::S_SCAN: begin
        if (idx_q < count_q) idx_d = idx_q + 1'b1;
        else st_d = (st_q == nfud_pkg::S_FIND) ? nfud_pkg::S_FIND_END
                                                : nfud_pkg::S_SCAN_END;
        if (st_q == nfud_pkg::S_FIND && v1_q && urd_q[15:0] == uid_q) begin
          hit_d = 1'b1; best_d = p1_q[UW-1:0];
        end
        if (st_q == nfud_pkg::S_SCAN && v2_q && f2_q && (!hit_q || cand_dist < bd_q)) begin
          hit_d = 1'b1; best_d = p2_q[UW-1:0]; bd_d = cand_dist; bid_d = id2_q;
        end
      end
      nfud_pkg::S_FIND_END: begin
        if (v1_q && urd_q[15:0] == uid_q) begin
          hit_d = 1'b1; best_d = p1_q[UW-1:0];
        end
        st_d = nfud_pkg::S_APPLY;
      end
      nfud_pkg::S_SCAN_END: begin
        if (v2_q && f2_q && (!hit_q || cand_dist < bd_q)) begin
          hit_d = 1'b1; best_d = p2_q[UW-1:0]; bd_d = cand_dist; bid_d = id2_q;
        end
        if (!v1_q && !v2_q) st_d = nfud_pkg::S_APPLY;
      end
      nfud_pkg::S_QREAD: st_d = nfud_pkg::S_QWAIT;
      nfud_pkg::S_QWAIT: begin
        cid_d = qrd_q[15:0]; pick_d = qrd_q[47:16]; dest_d = qrd_q[79:48];
        idx_d = '0; hit_d = 1'b0; serve_d = 1'b1;
        st_d = nfud_pkg::S_SCAN;
      end
      nfud_pkg::S_APPLY: begin
        if (out_free) begin
          ov_d = 1'b1; ouid_d = '0; ocid_d = '0; odist_d = '0; olast_d = 1'b1;
          ost_d = nfud_pkg::ST_DONE;
          st_d = nfud_pkg::S_IDLE;
          case (op_q)
            nfud_pkg::OP_ADD: begin
              if (count_q >= CW'(MAX_UNITS)) ost_d = nfud_pkg::ST_TFULL;
              else begin
                uwe = 1'b1; uwa = count_q[UW-1:0]; uwd = {pos_q, uid_q};
                free_d[count_q[UW-1:0]] = 1'b1; count_d = count_q + 1'b1;
              end
            end
            nfud_pkg::OP_MOVE: begin
              if (!hit_q) ost_d = nfud_pkg::ST_NOTFOUND;
              else begin
                uwe = 1'b1; uwa = best_q; uwd = {pos_q, uid_q};
              end
            end
            nfud_pkg::OP_SET: begin
              if (serve_q) begin
                if (hit_q) begin
                  free_d[best_q] = 1'b0;
                  uwe = 1'b1; uwa = best_q; uwd = {dest_q, bid_q};
                  ost_d = nfud_pkg::ST_ASSIGNED; ouid_d = bid_q; ocid_d = cid_q;
                  odist_d = bd_q; olast_d = 1'b0;
                  head_d = (head_q == QW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
                  fill_d = fill_q - 1'b1;
                  nres_d = nres_q + 1'b1;
                  if (fill_d != '0 && nres_d < 7'(nfud_pkg::MaxResults - 1))
                    st_d = nfud_pkg::S_QREAD;
                  else begin
                    st_d = nfud_pkg::S_EMIT;
                  end
                end else begin
                  ost_d = nfud_pkg::ST_DONE;
                end
              end else if (!hit_q) ost_d = nfud_pkg::ST_NOTFOUND;
              else begin
                free_d[best_q] = flag_q;
                if (flag_q && fill_q != '0) begin
                  ov_d = ov_q && stall_i;
                  st_d = nfud_pkg::S_QREAD;
                end
              end
            end
            default: begin
              ocid_d = cid_q;
              if (hit_q) begin
                free_d[best_q] = 1'b0;
                uwe = 1'b1; uwa = best_q; uwd = {dest_q, bid_q};
                ost_d = nfud_pkg::ST_ASSIGNED; ouid_d = bid_q; odist_d = bd_q;
              end else if (fill_q >= FW'(QUEUE_DEPTH)) ost_d = nfud_pkg::ST_QFULL;
              else begin
                qwe = 1'b1; qwd = {dest_q, pick_q, cid_q};
                tail_d = (tail_q == QW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
                fill_d = fill_q + 1'b1;
                ost_d = nfud_pkg::ST_QUEUED;
              end
            end
          endcase
        end
      end
      nfud_pkg::S_EMIT: begin
        if (out_free) begin
          ov_d = 1'b1; ost_d = nfud_pkg::ST_DONE; ouid_d = '0; ocid_d = '0;
          odist_d = '0; olast_d = 1'b1; st_d = nfud_pkg::S_IDLE;
        end
      end
      default: st_d = nfud_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= nfud_pkg::S_IDLE;
      free_q <= '0; count_q <= '0; head_q <= '0; tail_q <= '0; fill_q <= '0;
      ov_q <= 1'b0; v1_q <= 1'b0; v2_q <= 1'b0;
    end else begin
      st_q <= st_d;
      free_q <= free_d; count_q <= count_d; head_q <= head_d; tail_q <= tail_d;
      fill_q <= fill_d; ov_q <= ov_d;
      v1_q <= (st_q == nfud_pkg::S_FIND || st_q == nfud_pkg::S_SCAN) &&
              (idx_q < count_q);
      v2_q <= v1_q && (st_q == nfud_pkg::S_SCAN || st_q == nfud_pkg::S_SCAN_END);
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_in) begin
      op_q <= opcode_i; uid_q <= unit_id_i; pos_q <= {pos_y_i, pos_x_i};
      flag_q <= free_flag_i;
    end
    idx_q <= idx_d; hit_q <= hit_d; best_q <= best_d; bd_q <= bd_d; bid_q <= bid_d;
    nres_q <= nres_d; serve_q <= serve_d; cid_q <= cid_d; pick_q <= pick_d;
    dest_q <= dest_d;
    p1_q <= idx_q; p2_q <= p1_q;
    f1_q <= free_q[idx_q[UW-1:0]]; f2_q <= f1_q;
    id2_q <= urd_q[15:0];
    ost_q <= ost_d; ouid_q <= ouid_d; ocid_q <= ocid_d; odist_q <= odist_d;
    olast_q <= olast_d;
  end
endmodule
`default_nettype wire

@@ src/nfud_checker.sv @@
// Port-level checks for the dispatcher, bound to the top level.
// Depends on nfud_pkg.
`default_nettype none
module nfud_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       valid_i,
  input wire logic       stall_o,
  input wire logic       valid_o,
  input wire logic       stall_i,
  input wire logic [2:0] status_o,
  input wire logic       last_o,
  input wire logic [32:0] dist_sq_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(status_o)) else $error("result dropped");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !stall_o |=> stall_o) else $error("took second command");
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && status_o != nfud_pkg::ST_ASSIGNED && status_o != nfud_pkg::ST_DONE
    |-> last_o) else $error("error status not last");
  a_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && status_o != nfud_pkg::ST_ASSIGNED |-> dist_sq_o == '0)
    else $error("dist on non-assign");
endmodule

bind nearest_free_unit_dispatcher_top nfud_checker u_chk (.*);
`default_nettype wire
